// ===== hdl/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// tle_pkg: shared types and constants of the terminal line editor
// Character codes, echo sequences, result kinds and the line chain commands.
// ----------------------------------------------------------------------------
package tle_pkg;

	// received control characters
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_LBR = 8'h5B;
	localparam logic [7:0] CH_C   = 8'h43;
	localparam logic [7:0] CH_D   = 8'h44;
	// echo-only characters
	localparam logic [7:0] CH_X   = 8'h58;
	localparam logic [7:0] CH_P   = 8'h50;
	localparam logic [7:0] CH_AT  = 8'h40;
	localparam logic [7:0] CH_E   = 8'h45;

	// result kinds
	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_LINE = 2'd1;
	localparam logic [1:0] KIND_MARK = 2'd2;

	// echo sequences
	localparam logic [2:0] ECHO_BS_END = 3'd0;  // esc [ D esc [ X
	localparam logic [2:0] ECHO_BS_MID = 3'd1;  // esc [ D esc [ P
	localparam logic [2:0] ECHO_DEL    = 3'd2;  // esc [ P
	localparam logic [2:0] ECHO_INS    = 3'd3;  // esc [ @ char
	localparam logic [2:0] ECHO_CR     = 3'd4;  // esc E
	localparam logic [2:0] ECHO_RIGHT  = 3'd5;  // esc [ C
	localparam logic [2:0] ECHO_LEFT   = 3'd6;  // esc [ D
	localparam logic [2:0] ECHO_CHAR   = 3'd7;  // char

	// line chain command
	typedef enum logic [1:0] {
		CHAIN_IDLE,
		CHAIN_INSERT,
		CHAIN_DELETE,
		CHAIN_SHIFT
	} chain_op_t;

	typedef struct packed {
		chain_op_t  op;
		logic [7:0] chr;
	} chain_cmd_t;

	// per-cell operation
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT
	} cell_op_t;

	// number of bytes in an echo sequence
	function automatic logic [2:0] echo_len(input logic [2:0] id);
		logic [2:0] n;
		unique case (id)
			ECHO_BS_END, ECHO_BS_MID: n = 3'd6;
			ECHO_DEL, ECHO_RIGHT, ECHO_LEFT: n = 3'd3;
			ECHO_INS: n = 3'd4;
			ECHO_CR: n = 3'd2;
			ECHO_CHAR: n = 3'd1;
		endcase
		return n;
	endfunction

	// byte idx of an echo sequence, chr is the inserted character
	function automatic logic [7:0] echo_byte(input logic [2:0] id, input logic [2:0] idx,
			input logic [7:0] chr);
		logic [7:0][7:0] s;
		s = '0;
		unique case (id)
			ECHO_BS_END: begin
				s[0] = CH_ESC; s[1] = CH_LBR; s[2] = CH_D;
				s[3] = CH_ESC; s[4] = CH_LBR; s[5] = CH_X;
			end
			ECHO_BS_MID: begin
				s[0] = CH_ESC; s[1] = CH_LBR; s[2] = CH_D;
				s[3] = CH_ESC; s[4] = CH_LBR; s[5] = CH_P;
			end
			ECHO_DEL: begin
				s[0] = CH_ESC; s[1] = CH_LBR; s[2] = CH_P;
			end
			ECHO_INS: begin
				s[0] = CH_ESC; s[1] = CH_LBR; s[2] = CH_AT; s[3] = chr;
			end
			ECHO_CR: begin
				s[0] = CH_ESC; s[1] = CH_E;
			end
			ECHO_RIGHT: begin
				s[0] = CH_ESC; s[1] = CH_LBR; s[2] = CH_C;
			end
			ECHO_LEFT: begin
				s[0] = CH_ESC; s[1] = CH_LBR; s[2] = CH_D;
			end
			ECHO_CHAR: begin
				s[0] = chr;
			end
		endcase
		return s[idx];
	endfunction

endpackage

// ===== hdl/tle_cell.sv =====
// ----------------------------------------------------------------------------
// tle_cell: one character position of the line chain
// Holds one byte; loads a new byte or takes its left or right neighbor's byte.
// ----------------------------------------------------------------------------
module tle_cell (
	input  logic              clk,
	input  tle_pkg::cell_op_t op,
	input  logic [7:0]        chr_new,
	input  logic [7:0]        chr_left,
	input  logic [7:0]        chr_right,
	output logic [7:0]        chr
);
	import tle_pkg::*;

	logic [7:0] chr_q;

	// character register, undefined until written
	always_ff @(posedge clk) begin
		unique case (op)
			CELL_HOLD:       chr_q <= chr_q;
			CELL_LOAD:       chr_q <= chr_new;
			CELL_FROM_LEFT:  chr_q <= chr_left;
			CELL_FROM_RIGHT: chr_q <= chr_right;
		endcase
	end

	assign chr = chr_q;

endmodule

// ===== hdl/tle_line.sv =====
// ----------------------------------------------------------------------------
// tle_line: row of character cells holding the edit line
// Insert shifts the tail right, delete shifts it left, shift-out drains cell 0.
// ----------------------------------------------------------------------------
module tle_line #(
	parameter int LINE_MAX = 32,
	parameter int PW       = 6
) (
	input  logic                clk,
	input  tle_pkg::chain_cmd_t cmd,
	input  logic [PW-1:0]       pos,
	output logic [7:0]          head
);
	import tle_pkg::*;

	logic [7:0] chr [LINE_MAX];

	for (genvar i = 0; i < LINE_MAX; i++) begin : g_cell
		cell_op_t   op;
		logic [7:0] left;
		logic [7:0] right;

		// neighbor bytes, zero past the right end
		if (i == 0) begin : g_first
			assign left = cmd.chr;
		end else begin : g_mid
			assign left = chr[i-1];
		end
		if (i == LINE_MAX - 1) begin : g_last
			assign right = 8'h00;
		end else begin : g_inner
			assign right = chr[i+1];
		end

		// per-cell operation from the chain command
		always_comb begin
			op = CELL_HOLD;
			unique case (cmd.op)
				CHAIN_IDLE: op = CELL_HOLD;
				CHAIN_INSERT: begin
					if (PW'(i) == pos) op = CELL_LOAD;
					else if (PW'(i) > pos) op = CELL_FROM_LEFT;
				end
				CHAIN_DELETE: begin
					if (PW'(i) >= pos) op = CELL_FROM_RIGHT;
				end
				CHAIN_SHIFT: op = CELL_FROM_RIGHT;
			endcase
		end

		tle_cell u_cell (
			.clk       (clk),
			.op        (op),
			.chr_new   (cmd.chr),
			.chr_left  (left),
			.chr_right (right),
			.chr       (chr[i])
		);
	end

	assign head = chr[0];

endmodule

// ===== hdl/terminal_line_editor_core.sv =====
// ----------------------------------------------------------------------------
// terminal_line_editor_core: line editor for a serial terminal
// Parses ESC [ sequences, edits a line held in a chain of character cells and
// streams echo bytes, finished line bytes and an end marker.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | contents
//  s_      | in  | tvalid/tready     | tdata: received byte
//  m_      | out | tvalid/tready     | tdata: byte, nonempty flag; tuser: kind;
//          |     |                   | tlast: final word of an input byte
//
// an input byte edits the line in the cycle it is taken; its results then leave
// one per cycle while m_ does not stall, through the output register: up to 6 words
// for an edit, 3 + line length for carriage return
// the next byte is taken once the sequencer has handed off its last word
// a stall on m_ holds the sequencer; reset clears mode, cursor and length,
// line cells keep their contents and need no clearing pass
// ----------------------------------------------------------------------------
module terminal_line_editor_core #(
	parameter int LINE_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [8] line_nonempty, zero above
	output logic [1:0]  m_tuser,   // [1:0] out_kind
	output logic        m_tlast    // last
);
	import tle_pkg::*;

	localparam int PW = $clog2(LINE_MAX + 1);

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_ESC    = 2'd1;
	localparam logic [1:0] MODE_CSI    = 2'd2;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ECHO = 2'd1;
	localparam logic [1:0] ST_DUMP = 2'd2;
	localparam logic [1:0] ST_MARK = 2'd3;

	logic [1:0]    mode_q, mode_d;
	logic [PW-1:0] cur_q, cur_d;
	logic [PW-1:0] len_q, len_d;
	logic [1:0]    state_q;
	logic [2:0]    echo_id_q, echo_id_d;
	logic [2:0]    idx_q;
	logic          cr_q, cr_d;
	logic          ne_q;
	logic [PW-1:0] dump_cnt_q;
	logic [7:0]    chr_q;
	logic          start;
	logic          accept;
	logic          out_free;
	logic          emit;
	logic          echo_done;
	chain_op_t     edit_op;
	logic [PW-1:0] edit_pos;
	chain_cmd_t    cmd;
	logic [PW-1:0] cmd_pos;
	logic [7:0]    head;

	logic          m_tvalid_q;
	logic [1:0]    kind_q;
	logic [7:0]    byte_q;
	logic          nonempty_q;
	logic          last_q;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign emit     = out_free && (state_q != ST_IDLE);
	assign echo_done = (idx_q == echo_len(echo_id_q) - 3'd1);

	// decode of one received byte
	always_comb begin
		mode_d    = MODE_NORMAL;
		cur_d     = cur_q;
		len_d     = len_q;
		start     = 1'b0;
		echo_id_d = ECHO_CHAR;
		cr_d      = 1'b0;
		edit_op   = CHAIN_IDLE;
		edit_pos  = cur_q;
		unique case (mode_q)
			MODE_ESC: begin
				mode_d = (s_tdata == CH_LBR) ? MODE_CSI : MODE_NORMAL;
			end
			MODE_CSI: begin
				if (s_tdata == CH_C && cur_q < len_q) begin
					cur_d = cur_q + PW'(1); start = 1'b1; echo_id_d = ECHO_RIGHT;
				end else if (s_tdata == CH_D && cur_q != '0) begin
					cur_d = cur_q - PW'(1); start = 1'b1; echo_id_d = ECHO_LEFT;
				end
			end
			default: begin
				if (s_tdata == CH_BS) begin
					if (cur_q != '0) begin
						cur_d = cur_q - PW'(1);
						len_d = len_q - PW'(1);
						start = 1'b1;
						if (cur_q == len_q) begin
							echo_id_d = ECHO_BS_END;
						end else begin
							echo_id_d = ECHO_BS_MID;
							edit_op   = CHAIN_DELETE;
							edit_pos  = cur_q - PW'(1);
						end
					end
				end else if (s_tdata == CH_CR) begin
					cur_d = '0; len_d = '0; start = 1'b1;
					echo_id_d = ECHO_CR; cr_d = 1'b1;
				end else if (s_tdata == CH_ESC) begin
					mode_d = MODE_ESC;
				end else if (s_tdata == CH_DEL) begin
					if (cur_q < len_q) begin
						len_d = len_q - PW'(1); start = 1'b1;
						echo_id_d = ECHO_DEL; edit_op = CHAIN_DELETE;
					end
				end else if (len_q < PW'(LINE_MAX)) begin
					cur_d = cur_q + PW'(1); len_d = len_q + PW'(1); start = 1'b1;
					edit_op = CHAIN_INSERT;
					echo_id_d = (cur_q == len_q) ? ECHO_CHAR : ECHO_INS;
				end
			end
		endcase
	end

	// chain command: edit on accept, drain during line dump
	always_comb begin
		cmd.chr = s_tdata;
		cmd_pos = edit_pos;
		if (accept) begin
			cmd.op = edit_op;
		end else if (state_q == ST_DUMP && out_free) begin
			cmd.op = CHAIN_SHIFT;
		end else begin
			cmd.op = CHAIN_IDLE;
		end
	end

	tle_line #(
		.LINE_MAX (LINE_MAX),
		.PW       (PW)
	) u_line (
		.clk  (clk),
		.cmd  (cmd),
		.pos  (cmd_pos),
		.head (head)
	);

	// editor state and result sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_NORMAL;
			cur_q      <= '0;
			len_q      <= '0;
			state_q    <= ST_IDLE;
			echo_id_q  <= ECHO_CHAR;
			idx_q      <= '0;
			cr_q       <= 1'b0;
			ne_q       <= 1'b0;
			dump_cnt_q <= '0;
		end else begin
			if (accept) begin
				mode_q <= mode_d;
				cur_q  <= cur_d;
				len_q  <= len_d;
				if (start) begin
					state_q    <= ST_ECHO;
					echo_id_q  <= echo_id_d;
					idx_q      <= '0;
					cr_q       <= cr_d;
					ne_q       <= (len_q != '0);
					dump_cnt_q <= len_q;
				end
			end else if (emit) begin
				unique case (state_q)
					ST_ECHO: begin
						idx_q <= idx_q + 3'd1;
						if (echo_done) begin
							if (!cr_q) state_q <= ST_IDLE;
							else if (dump_cnt_q != '0) state_q <= ST_DUMP;
							else state_q <= ST_MARK;
						end
					end
					ST_DUMP: begin
						dump_cnt_q <= dump_cnt_q - PW'(1);
						if (dump_cnt_q == PW'(1)) state_q <= ST_MARK;
					end
					ST_MARK: state_q <= ST_IDLE;
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// held character for insert echo
	always_ff @(posedge clk) begin
		if (accept) chr_q <= s_tdata;
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (emit) begin
			unique case (state_q)
				ST_ECHO: begin
					kind_q     <= KIND_ECHO;
					byte_q     <= echo_byte(echo_id_q, idx_q, chr_q);
					nonempty_q <= 1'b0;
					last_q     <= echo_done && !cr_q;
				end
				ST_DUMP: begin
					kind_q     <= KIND_LINE;
					byte_q     <= head;
					nonempty_q <= 1'b0;
					last_q     <= 1'b0;
				end
				default: begin
					kind_q     <= KIND_MARK;
					byte_q     <= 8'h00;
					nonempty_q <= ne_q;
					last_q     <= 1'b1;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, nonempty_q, byte_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	// cursor never passes the end of the line
	a_cursor_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q)
		else $error("cursor beyond line length");

	// line never exceeds its store
	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= PW'(LINE_MAX))
		else $error("line length beyond store");

	// a line dump always has bytes left to send
	a_dump_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP |-> dump_cnt_q != '0)
		else $error("line dump with empty count");

	// end marker closes the results of its byte
	a_mark_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && kind_q == KIND_MARK |-> last_q)
		else $error("end marker not flagged last");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for terminal_line_editor_core
// Sends received bytes on s_ and follows them with its own copy of the line,
// cursor and escape parser, queuing the echo, line and end marker words each
// byte should cause. Every word taken on m_ is compared with the oldest queued
// one. Both sides pause at random, and the sink holds off once for a long time.
// ----------------------------------------------------------------------------
module testbench;
	import tle_pkg::*;

	localparam int LINE_CAP    = 32;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_WAIT  = 48;
	localparam int RANDOM_KEYS = 270;

	// escape parser phase
	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_SEEN,
		ESC_CSI
	} esc_phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       nonempty;
		logic       last;
	} word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] in_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;    // [7:0] out_byte, [8] line_nonempty, zero above
	logic [1:0]  m_tuser;    // [1:0] out_kind
	logic        m_tlast;

	// shadow of the editor
	esc_phase_t  esc_phase;
	logic [7:0]  line_buf [LINE_CAP];
	int unsigned cursor;
	int unsigned length;
	word_t       pending_words [$];

	int unsigned fail_count  = 0;
	int unsigned bytes_sent  = 0;
	int unsigned idle_cycles = 0;
	int unsigned sink_hold   = 0;
	bit          gaps_on     = 1'b1;
	word_t       want;

	terminal_line_editor_core #(
		.LINE_MAX(LINE_CAP)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// line shadow
	// ------------------------------------------------------------------------
	function automatic void push_word(logic [1:0] kind, logic [7:0] data, logic nonempty);
		word_t w;
		w.kind     = kind;
		w.data     = data;
		w.nonempty = nonempty;
		w.last     = 1'b0;
		pending_words.push_back(w);
	endfunction

	// esc [ fin
	function automatic void push_csi(logic [7:0] fin);
		push_word(KIND_ECHO, CH_ESC, 1'b0);
		push_word(KIND_ECHO, CH_LBR, 1'b0);
		push_word(KIND_ECHO, fin, 1'b0);
	endfunction

	// drop the character under the cursor, tail moves left
	function automatic void close_gap();
		for (int unsigned i = cursor; i + 1 < length; i++)
			line_buf[i] = line_buf[i + 1];
		length--;
	endfunction

	function automatic void edit_plain(logic [7:0] b);
		case (b)
			CH_BS: begin
				if (cursor != 0) begin
					cursor--;
					push_csi(CH_D);
					if (cursor + 1 == length) begin
						length--;
						push_csi(CH_X);
					end else begin
						close_gap();
						push_csi(CH_P);
					end
				end
			end
			CH_CR: begin
				push_word(KIND_ECHO, CH_ESC, 1'b0);
				push_word(KIND_ECHO, CH_E, 1'b0);
				for (int unsigned i = 0; i < length; i++)
					push_word(KIND_LINE, line_buf[i], 1'b0);
				push_word(KIND_MARK, 8'h00, length != 0);
				length = 0;
				cursor = 0;
			end
			CH_ESC: begin
				esc_phase = ESC_SEEN;
			end
			CH_DEL: begin
				if (cursor < length) begin
					close_gap();
					push_csi(CH_P);
				end
			end
			default: begin
				// a full line swallows the character silently
				if (length < LINE_CAP) begin
					if (cursor != length) begin
						for (int unsigned i = length; i > cursor; i--)
							line_buf[i] = line_buf[i - 1];
						push_csi(CH_AT);
					end
					line_buf[cursor] = b;
					cursor++;
					length++;
					push_word(KIND_ECHO, b, 1'b0);
				end
			end
		endcase
	endfunction

	function automatic void predict_keystroke(logic [7:0] b);
		int unsigned queued;
		word_t       tail;
		queued = pending_words.size();
		case (esc_phase)
			ESC_SEEN: begin
				esc_phase = (b == CH_LBR) ? ESC_CSI : ESC_NONE;
			end
			ESC_CSI: begin
				esc_phase = ESC_NONE;
				if (b == CH_C && cursor < length) begin
					cursor++;
					push_csi(CH_C);
				end else if (b == CH_D && cursor > 0) begin
					cursor--;
					push_csi(CH_D);
				end
			end
			default: begin
				esc_phase = ESC_NONE;
				edit_plain(b);
			end
		endcase
		// flag the final word of this byte
		if (pending_words.size() > queued) begin
			tail = pending_words.pop_back();
			tail.last = 1'b1;
			pending_words.push_back(tail);
		end
	endfunction

	// ------------------------------------------------------------------------
	// word checker
	// ------------------------------------------------------------------------
	task automatic check_field(string name, logic [7:0] exp, logic [7:0] act);
		if (act !== exp) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_words.size() == 0) begin
				$error("word with none expected: kind %0h byte %0h", m_tuser, m_tdata[7:0]);
				fail_count++;
			end else begin
				want = pending_words.pop_front();
				check_field("out_kind", 8'(want.kind), 8'(m_tuser));
				check_field("out_byte", want.data, m_tdata[7:0]);
				check_field("line_nonempty", 8'(want.nonempty), 8'(m_tdata[8]));
				check_field("tdata padding", 8'h00, 8'(m_tdata[15:9]));
				check_field("last", 8'(want.last), 8'(m_tlast));
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("terminal_line_editor_core: mismatch");
				$finish;
			end
		end
	end

	// sink: random pauses, plus a long hold when one is requested
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_hold != 0) begin
				m_tready <= 1'b0;
				repeat (sink_hold) @(posedge clk);
				sink_hold = 0;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// source
	// ------------------------------------------------------------------------
	task automatic send_byte(logic [7:0] b);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		predict_keystroke(b);
		bytes_sent++;
	endtask

	task automatic send_csi(logic [7:0] fin);
		send_byte(CH_ESC);
		send_byte(CH_LBR);
		send_byte(fin);
	endtask

	function automatic logic [7:0] printable();
		return 8'($urandom_range(8'h20, 8'h7E));
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// keys with nothing to act on, then an empty line
	task automatic test_empty_line_keys();
		send_byte(CH_BS);
		send_byte(CH_DEL);
		send_csi(CH_D);
		send_csi(CH_C);
		send_byte(CH_CR);
	endtask

	// inserts at the end and in the middle, cursor moves, deletes before and under the cursor
	task automatic test_edit_keys();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h61);
		send_csi(CH_D);
		send_csi(CH_D);
		send_byte(8'h5A);
		send_csi(CH_C);
		send_byte(CH_DEL);
		send_byte(CH_BS);
		send_csi(CH_C);
		send_csi(CH_C);
		send_byte(CH_BS);
		send_byte(CH_CR);
	endtask

	// broken escapes are dropped
	task automatic test_escape_drops();
		send_byte(CH_ESC);
		send_byte(8'h78);
		send_byte(CH_ESC);
		send_byte(CH_ESC);
		send_byte(CH_LBR);
		send_byte(CH_ESC);
		send_byte(CH_LBR);
		send_byte(8'h5A);
		send_byte(CH_ESC);
		send_byte(CH_LBR);
		send_byte(CH_ESC);
		send_byte(CH_CR);
	endtask

	// fill the line, then try inserts at the end and in the middle
	task automatic test_full_line();
		for (int i = 0; i < LINE_CAP + 2; i++)
			send_byte(printable());
		send_csi(CH_D);
		send_byte(8'h71);
		send_byte(CH_DEL);
		send_byte(8'h71);
		send_byte(8'h72);
		send_byte(CH_CR);
	endtask

	// sink stops for a long stretch while bytes keep coming
	task automatic test_backpressure();
		sink_hold = 300;
		for (int i = 0; i < 24; i++)
			send_byte(printable());
		send_byte(CH_CR);
	endtask

	task automatic test_random_edits(int unsigned count);
		int unsigned start;
		int unsigned pick;
		start = bytes_sent;
		while (bytes_sent - start < count) begin
			if (bytes_sent - start + 100 >= count)
				gaps_on = 1'b0;
			else if ($urandom_range(0, 15) == 0)
				gaps_on = !gaps_on;
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_byte(printable());
			else if (pick < 48)
				send_byte(8'($urandom_range(0, 255)));
			else if (pick < 56)
				send_byte(CH_BS);
			else if (pick < 62)
				send_byte(CH_DEL);
			else if (pick < 74)
				send_csi($urandom_range(0, 1) ? CH_C : CH_D);
			else if (pick < 78) begin
				send_byte(CH_ESC);
				send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 82) begin
				send_byte(CH_ESC);
				send_byte(CH_LBR);
				send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 85)
				send_byte(CH_CR);
			else if (pick < 95)
				repeat ($urandom_range(1, 5)) send_csi(CH_D);
			else
				repeat ($urandom_range(3, 8)) send_byte(printable());
		end
		send_byte(CH_CR);
	endtask

	// ------------------------------------------------------------------------
	// run
	// ------------------------------------------------------------------------
	initial begin
		esc_phase = ESC_NONE;
		cursor    = 0;
		length    = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_line_keys();
		test_edit_keys();
		test_escape_drops();
		test_full_line();
		test_backpressure();
		test_random_edits(RANDOM_KEYS);

		s_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fail_count == 0)
			$display("terminal_line_editor_core: match");
		else
			$display("terminal_line_editor_core: mismatch");
		$finish;
	end

endmodule
